FILE: design/qte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg: shared types, constants and functions
// Number formats, CORDIC angle table and rounding helpers for the
// quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int QUAT_W          = 16;
   localparam int TERM_W          = 32;   // Q2.30 terms
   localparam int CORDIC_STEPS    = 16;
   localparam int TABLE_LEN       = 24;
   localparam int RUN_STEPS       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int SH              = 30 - ANGLE_FRAC_BITS;
   localparam int XW              = 36;   // CORDIC vector width
   localparam int ZW              = 34;   // CORDIC angle accumulator width
   localparam int SQ_STEPS        = 31;   // one result bit per square root stage
   localparam int RAD_W           = 31;
   localparam int PITCH_W         = 15;
   localparam int ROLL_W          = 16;
   localparam int YAW_W           = 16;

   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint HALF_LSB    = 64'sd1 <<< (SH - 1);

   localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(HALF_PI_Q30);
   localparam logic signed [ZW-1:0] PI_LIM    = ZW'((PI_Q30 + HALF_LSB) >>> SH);
   localparam logic signed [ZW-1:0] HPI_LIM   = ZW'((HALF_PI_Q30 + HALF_LSB) >>> SH);

   typedef logic signed [TERM_W-1:0] term_type;

   typedef struct packed {
      term_type t0;
      term_type t1;
      term_type t2;
      term_type t3;
      term_type t4;
   } terms_type;

   // Saturate a widened sum to the Q2.30 term range.
   function automatic term_type sat_term(input logic signed [34:0] v);
      term_type r;
      if (v > 35'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -35'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = TERM_W'(v);
      end
      return r;
   endfunction

   function automatic logic signed [ZW-1:0] atan_entry(input int i);
      logic signed [ZW-1:0] a;
      unique case (i)
         0:  a = ZW'(64'h3243F6A8);
         1:  a = ZW'(64'h1DAC6705);
         2:  a = ZW'(64'h0FADBAFC);
         3:  a = ZW'(64'h07F56EA6);
         4:  a = ZW'(64'h03FEAB76);
         5:  a = ZW'(64'h01FFD55B);
         6:  a = ZW'(64'h00FFFAAA);
         7:  a = ZW'(64'h007FFF55);
         8:  a = ZW'(64'h003FFFEA);
         9:  a = ZW'(64'h001FFFFD);
         10: a = ZW'(64'h000FFFFF);
         11: a = ZW'(64'h0007FFFF);
         12: a = ZW'(64'h0003FFFF);
         13: a = ZW'(64'h0001FFFF);
         14: a = ZW'(64'h0000FFFF);
         15: a = ZW'(64'h00007FFF);
         16: a = ZW'(64'h00003FFF);
         17: a = ZW'(64'h00001FFF);
         18: a = ZW'(64'h00000FFF);
         19: a = ZW'(64'h000007FF);
         20: a = ZW'(64'h000003FF);
         21: a = ZW'(64'h000001FF);
         22: a = ZW'(64'h000000FF);
         23: a = ZW'(64'h0000007F);
         default: a = '0;
      endcase
      return a;
   endfunction

   // Round half up from Q2.30 to the output fraction and clamp to +-lim.
   function automatic logic signed [ZW-1:0] round_angle(input logic signed [ZW-1:0] z,
                                                        input logic signed [ZW-1:0] lim);
      logic signed [ZW:0] s;
      logic signed [ZW:0] r;
      logic signed [ZW:0] l;
      s = (ZW+1)'(z) + (ZW+1)'(HALF_LSB);
      r = s >>> SH;
      l = (ZW+1)'(lim);
      if (r > l) begin
         r = l;
      end else if (r < -l) begin
         r = -l;
      end
      return ZW'(r);
   endfunction

endpackage

FILE: design/qte_terms.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_terms: quaternion products and rotation terms
// Three stages: products, saturated terms with pitch clamp, and the
// radicand 1 - t2^2 for the square root.
// ----------------------------------------------------------------------------
module qte_terms (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic signed [qte_pkg::QUAT_W-1:0] quat_w,
   input  logic signed [qte_pkg::QUAT_W-1:0] quat_x,
   input  logic signed [qte_pkg::QUAT_W-1:0] quat_y,
   input  logic signed [qte_pkg::QUAT_W-1:0] quat_z,
   output logic                             out_valid,
   output qte_pkg::terms_type               out_terms,
   output logic [60:0]                      out_rad
);

   logic                      v1_ff, v2_ff, v3_ff;
   logic signed [31:0]        xx_ff, yy_ff, zz_ff, xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   qte_pkg::terms_type        t2_ff, t2_in, t3_ff;
   logic [60:0]               rad_ff, rad_in;
   logic signed [34:0]        e0, e1, e2, e3, e4;
   qte_pkg::term_type         p2;
   logic [30:0]               mag;
   logic [61:0]               sq;

   always_comb begin
      e0 = (35'sd1 <<< 30) - ((35'(yy_ff) + 35'(zz_ff)) <<< 1);
      e1 = (35'(xy_ff) + 35'(wz_ff)) <<< 1;
      e2 = (35'(wy_ff) - 35'(xz_ff)) <<< 1;
      e3 = (35'(yz_ff) + 35'(wx_ff)) <<< 1;
      e4 = (35'sd1 <<< 30) - ((35'(xx_ff) + 35'(yy_ff)) <<< 1);
      p2 = qte_pkg::sat_term(e2);
      if (p2 > 32'sd1073741824) begin
         p2 = 32'sd1073741824;
      end else if (p2 < -32'sd1073741824) begin
         p2 = -32'sd1073741824;
      end
      t2_in.t0 = qte_pkg::sat_term(e0);
      t2_in.t1 = qte_pkg::sat_term(e1);
      t2_in.t2 = p2;
      t2_in.t3 = qte_pkg::sat_term(e3);
      t2_in.t4 = qte_pkg::sat_term(e4);
   end

   // |t2| is at most 2^30, so the square fits 61 bits.
   always_comb begin
      mag    = t2_ff.t2[31] ? 31'(-t2_ff.t2) : 31'(t2_ff.t2);
      sq     = 62'(mag) * 62'(mag);
      rad_in = 61'((62'd1 << 60) - sq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff  <= quat_x * quat_x;
         yy_ff  <= quat_y * quat_y;
         zz_ff  <= quat_z * quat_z;
         xy_ff  <= quat_x * quat_y;
         wz_ff  <= quat_w * quat_z;
         xz_ff  <= quat_x * quat_z;
         wy_ff  <= quat_w * quat_y;
         yz_ff  <= quat_y * quat_z;
         wx_ff  <= quat_w * quat_x;
         t2_ff  <= t2_in;
         t3_ff  <= t2_ff;
         rad_ff <= rad_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_terms = t3_ff;
   assign out_rad   = rad_ff;

endmodule

FILE: design/qte_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_sqrt: pipelined integer square root
// Restoring square root, one result bit per stage, with the remaining terms
// carried alongside so they leave together with the root.
// ----------------------------------------------------------------------------
module qte_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  qte_pkg::terms_type                in_terms,
   input  logic [60:0]                       in_rad,
   output logic                              out_valid,
   output qte_pkg::terms_type                out_terms,
   output logic [qte_pkg::RAD_W-1:0]         out_root
);

   localparam int N = qte_pkg::SQ_STEPS;

   logic               vld_ff   [0:N-1];
   logic [61:0]        rem_ff   [0:N-1];
   logic [61:0]        res_ff   [0:N-1];
   qte_pkg::terms_type terms_ff [0:N-1];

   for (genvar j = 0; j < N; j++) begin : g_step
      localparam logic [61:0] BITV = 62'd1 << (2 * (N - 1 - j));
      logic               vld_p;
      logic [61:0]        rem_p, res_p, sum, rem_in, res_in;
      qte_pkg::terms_type terms_p;

      if (j == 0) begin : g_first
         assign vld_p   = in_valid;
         assign rem_p   = 62'(in_rad);
         assign res_p   = '0;
         assign terms_p = in_terms;
      end else begin : g_next
         assign vld_p   = vld_ff[j-1];
         assign rem_p   = rem_ff[j-1];
         assign res_p   = res_ff[j-1];
         assign terms_p = terms_ff[j-1];
      end

      always_comb begin
         sum = res_p + BITV;
         if (rem_p >= sum) begin
            rem_in = rem_p - sum;
            res_in = (res_p >> 1) + BITV;
         end else begin
            rem_in = rem_p;
            res_in = res_p >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]   <= rem_in;
            res_ff[j]   <= res_in;
            terms_ff[j] <= terms_p;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_terms = terms_ff[N-1];
   assign out_root  = res_ff[N-1][qte_pkg::RAD_W-1:0];

endmodule

FILE: design/qte_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic: pipelined CORDIC arctangent
// A quarter-turn prerotation stage followed by one vectoring iteration per
// stage; returns atan2(y, x) in Q2.30 radians.
// ----------------------------------------------------------------------------
module qte_cordic (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [qte_pkg::TERM_W-1:0] in_y,
   input  logic signed [qte_pkg::TERM_W-1:0] in_x,
   output logic                              out_valid,
   output logic signed [qte_pkg::ZW-1:0]     out_angle
);

   localparam int N  = qte_pkg::RUN_STEPS;
   localparam int XW = qte_pkg::XW;
   localparam int ZW = qte_pkg::ZW;

   logic                 vld_ff  [0:N];
   logic                 zero_ff [0:N];
   logic signed [XW-1:0] x_ff    [0:N];
   logic signed [XW-1:0] y_ff    [0:N];
   logic signed [ZW-1:0] z_ff    [0:N];

   logic signed [XW-1:0] xe, ye, x_in, y_in;
   logic signed [ZW-1:0] z_in;

   // Vectors in the left half plane are turned by a quarter turn first.
   always_comb begin
      xe = XW'(in_x);
      ye = XW'(in_y);
      if (xe < 0) begin
         if (ye >= 0) begin
            z_in = qte_pkg::HALF_PI_Z;
            x_in = ye;
            y_in = -xe;
         end else begin
            z_in = -qte_pkg::HALF_PI_Z;
            x_in = -ye;
            y_in = xe;
         end
      end else begin
         z_in = '0;
         x_in = xe;
         y_in = ye;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (in_x == '0) && (in_y == '0);
         x_ff[0]    <= x_in;
         y_ff[0]    <= y_in;
         z_ff[0]    <= z_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_iter
      localparam logic signed [ZW-1:0] ANG = qte_pkg::atan_entry(i);
      logic signed [XW-1:0] dx, dy, xs_in, ys_in;
      logic signed [ZW-1:0] zs_in;

      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         if (y_ff[i] >= 0) begin
            xs_in = x_ff[i] + dx;
            ys_in = y_ff[i] - dy;
            zs_in = z_ff[i] + ANG;
         end else begin
            xs_in = x_ff[i] - dx;
            ys_in = y_ff[i] + dy;
            zs_in = z_ff[i] - ANG;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            x_ff[i+1]    <= xs_in;
            y_ff[i+1]    <= ys_in;
            z_ff[i+1]    <= zs_in;
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_angle = zero_ff[N] ? '0 : z_ff[N];

endmodule

FILE: design/quaternion_to_euler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit: attitude quaternion to ZYX Euler angles
// Q1.15 quaternion in; pitch in Q2.13, roll and yaw in Q3.13 radians out.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  req     | in        | req_valid, req_ready, req_quat_w/x/y/z
//  rsp     | out       | rsp_valid, rsp_ready, rsp_pitch/roll/yaw_angle
//
// One transaction may enter every cycle while the pipeline is not held. The
// stages are 3 term stages, 31 square root stages (one root bit each),
// 1 prerotation plus 16 CORDIC iteration stages, and the output register.
// The pipeline advances as a whole; it holds only while the output
// register is full and rsp_ready is low, and then req_ready is low too.
// Reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [qte_pkg::QUAT_W-1:0]  req_quat_w,
   input  logic signed [qte_pkg::QUAT_W-1:0]  req_quat_x,
   input  logic signed [qte_pkg::QUAT_W-1:0]  req_quat_y,
   input  logic signed [qte_pkg::QUAT_W-1:0]  req_quat_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [qte_pkg::PITCH_W-1:0] rsp_pitch_angle,
   output logic signed [qte_pkg::ROLL_W-1:0]  rsp_roll_angle,
   output logic signed [qte_pkg::YAW_W-1:0]   rsp_yaw_angle
);

   logic                             en;
   logic                             tv, sv, pv, rv, yv;
   qte_pkg::terms_type               tt, st;
   logic [60:0]                      rad;
   logic [qte_pkg::RAD_W-1:0]        root;
   logic signed [qte_pkg::ZW-1:0]    pz, rz, yz;
   logic                             out_valid_ff;
   logic signed [qte_pkg::PITCH_W-1:0] pitch_ff;
   logic signed [qte_pkg::ROLL_W-1:0]  roll_ff;
   logic signed [qte_pkg::YAW_W-1:0]   yaw_ff;

   assign en        = !out_valid_ff || rsp_ready;
   assign req_ready = en;

   qte_terms u_terms (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .quat_w    (req_quat_w),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .out_valid (tv),
      .out_terms (tt),
      .out_rad   (rad)
   );

   qte_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (tv),
      .in_terms  (tt),
      .in_rad    (rad),
      .out_valid (sv),
      .out_terms (st),
      .out_root  (root)
   );

   qte_cordic u_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sv),
      .in_y      (st.t2),
      .in_x      ($signed({1'b0, root})),
      .out_valid (pv),
      .out_angle (pz)
   );

   qte_cordic u_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sv),
      .in_y      (st.t3),
      .in_x      (st.t4),
      .out_valid (rv),
      .out_angle (rz)
   );

   qte_cordic u_yaw (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sv),
      .in_y      (st.t1),
      .in_x      (st.t0),
      .out_valid (yv),
      .out_angle (yz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= pv && rv && yv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pitch_ff <= qte_pkg::PITCH_W'(qte_pkg::round_angle(pz, qte_pkg::HPI_LIM));
         roll_ff  <= qte_pkg::ROLL_W'(qte_pkg::round_angle(rz, qte_pkg::PI_LIM));
         yaw_ff   <= qte_pkg::YAW_W'(qte_pkg::round_angle(yz, qte_pkg::PI_LIM));
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_roll_angle  = roll_ff;
   assign rsp_yaw_angle   = yaw_ff;

endmodule

FILE: design/qte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_checker: port-level checks for the quaternion to Euler unit
// Watches the handshake and the output angle ranges.
// ----------------------------------------------------------------------------
module qte_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [qte_pkg::PITCH_W-1:0] rsp_pitch_angle,
   input logic signed [qte_pkg::ROLL_W-1:0]  rsp_roll_angle,
   input logic signed [qte_pkg::YAW_W-1:0]   rsp_yaw_angle
);

   // A stalled result keeps its value until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pitch_angle)
         && $stable(rsp_roll_angle) && $stable(rsp_yaw_angle))
      else $error("stalled result changed");

   // Input is refused exactly when a full output register is stalled.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow the output stall");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch_angle <= 15'sd12868 && rsp_pitch_angle >= -15'sd12868)
      else $error("pitch out of range");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_roll_angle <= 16'sd25736 && rsp_roll_angle >= -16'sd25736
         && rsp_yaw_angle <= 16'sd25736 && rsp_yaw_angle >= -16'sd25736)
      else $error("roll or yaw out of range");

endmodule

bind quaternion_to_euler_unit qte_checker u_qte_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pitch_angle (rsp_pitch_angle),
   .rsp_roll_angle  (rsp_roll_angle),
   .rsp_yaw_angle   (rsp_yaw_angle)
);

FILE: test/quaternion_to_euler_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit_tb: self-checking bench for the Euler angle unit
// Drives quaternions through the valid/ready request channel, predicts the
// pitch, roll and yaw angles with a bit-exact fixed-point model and compares
// every response transaction in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module quaternion_to_euler_unit_tb;

   localparam int LATENCY     = 52;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [qte_pkg::PITCH_W-1:0] pitch;
      logic signed [qte_pkg::ROLL_W-1:0]  roll;
      logic signed [qte_pkg::YAW_W-1:0]   yaw;
   } angles_type;

   class angle_scoreboard;
      angles_type pending[$];
      int         errors;
      int         matched;

      static function longint shr(longint v, int s);
         return v >>> s;
      endfunction

      static function longint clip_term(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      static function longint int_root(longint v);
         longint r;
         longint b;
         r = 0;
         b = 64'sd1 <<< 62;
         while (b > v) b = b >>> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >>> 1) + b;
            end else begin
               r = r >>> 1;
            end
            b = b >>> 2;
         end
         return r;
      endfunction

      static function longint arctan_q30(longint ay, longint ax);
         longint acc;
         longint dx;
         longint dy;
         longint tmp;
         longint tbl[24];
         tbl = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
                 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
                 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
                 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
         acc = 0;
         if (ax == 0 && ay == 0) return 0;
         // Vectors in the left half plane start with a quarter turn.
         if (ax < 0) begin
            if (ay >= 0) begin
               acc = qte_pkg::HALF_PI_Q30;
               tmp = ay;
               ay = -ax;
               ax = tmp;
            end else begin
               acc = -qte_pkg::HALF_PI_Q30;
               tmp = -ay;
               ay = ax;
               ax = tmp;
            end
         end
         for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < 24; i++) begin
            dx = shr(ay, i);
            dy = shr(ax, i);
            if (ay >= 0) begin
               ax = ax + dx;
               ay = ay - dy;
               acc = acc + tbl[i];
            end else begin
               ax = ax - dx;
               ay = ay + dy;
               acc = acc - tbl[i];
            end
         end
         return acc;
      endfunction

      static function longint quantize(longint a, longint lim_q30);
         longint half;
         longint r;
         longint l;
         half = 64'sd1 <<< (qte_pkg::SH - 1);
         r = shr(a + half, qte_pkg::SH);
         l = shr(lim_q30 + half, qte_pkg::SH);
         if (r > l) r = l;
         if (r < -l) r = -l;
         return r;
      endfunction

      function void note_quaternion(logic signed [15:0] qw, logic signed [15:0] qx,
                                    logic signed [15:0] qy, logic signed [15:0] qz);
         longint w, x, y, z, yy, t0, t1, t2, t3, t4, rad;
         angles_type e;
         w = qw; x = qx; y = qy; z = qz;
         yy = y * y;
         t0 = clip_term((64'sd1 <<< 30) - 2 * (yy + z * z));
         t1 = clip_term(2 * (x * y + w * z));
         t2 = clip_term(-2 * (x * z - w * y));
         t3 = clip_term(2 * (y * z + w * x));
         t4 = clip_term((64'sd1 <<< 30) - 2 * (x * x + yy));
         if (t2 > (64'sd1 <<< 30)) t2 = 64'sd1 <<< 30;
         if (t2 < -(64'sd1 <<< 30)) t2 = -(64'sd1 <<< 30);
         rad = int_root((64'sd1 <<< 60) - t2 * t2);
         e.pitch = qte_pkg::PITCH_W'(quantize(arctan_q30(t2, rad), qte_pkg::HALF_PI_Q30));
         e.roll  = qte_pkg::ROLL_W'(quantize(arctan_q30(t3, t4), qte_pkg::PI_Q30));
         e.yaw   = qte_pkg::YAW_W'(quantize(arctan_q30(t1, t0), qte_pkg::PI_Q30));
         pending = {pending, e};
      endfunction

      function void check_angles(logic signed [qte_pkg::PITCH_W-1:0] p,
                                 logic signed [qte_pkg::ROLL_W-1:0] r,
                                 logic signed [qte_pkg::YAW_W-1:0] y);
         angles_type e;
         if (pending.size() == 0) begin
            $error("unexpected response transaction");
            errors++;
            return;
         end
         e = pending.pop_front();
         matched++;
         if (p !== e.pitch) begin
            $error("pitch_angle expected %0d actual %0d", e.pitch, p);
            errors++;
         end
         if (r !== e.roll) begin
            $error("roll_angle expected %0d actual %0d", e.roll, r);
            errors++;
         end
         if (y !== e.yaw) begin
            $error("yaw_angle expected %0d actual %0d", e.yaw, y);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [qte_pkg::QUAT_W-1:0] req_quat_w = 0, req_quat_x = 0;
   logic signed [qte_pkg::QUAT_W-1:0] req_quat_y = 0, req_quat_z = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [qte_pkg::PITCH_W-1:0] rsp_pitch_angle;
   logic signed [qte_pkg::ROLL_W-1:0]  rsp_roll_angle;
   logic signed [qte_pkg::YAW_W-1:0]   rsp_yaw_angle;

   angle_scoreboard board = new();
   int  cycle_count = 0;
   bit  calm_phase = 0;
   bit  hold_off = 0;
   int  sent = 0;

   quaternion_to_euler_unit DUT (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_quaternion(req_quat_w, req_quat_x, req_quat_y, req_quat_z);
      if (!reset && rsp_valid && rsp_ready)
         board.check_angles(rsp_pitch_angle, rsp_roll_angle, rsp_yaw_angle);
   end

   // The receiver stalls about a quarter of the time, never in the calm phase.
   always @(posedge clock) begin
      if (reset || hold_off) rsp_ready <= 0;
      else rsp_ready <= calm_phase || ($urandom_range(99) >= 25);
   end

   // Send one quaternion, possibly after random idle cycles. Valid stays high
   // between back-to-back transactions.
   task automatic send_quaternion(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                                  logic [15:0] z);
      while (!calm_phase && $urandom_range(99) < 25) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_quat_w <= w; req_quat_x <= x; req_quat_y <= y; req_quat_z <= z;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic send_random();
      logic [15:0] q[4];
      int mode;
      mode = $urandom_range(9);
      for (int k = 0; k < 4; k++) begin
         if (mode < 6) q[k] = 16'($signed($urandom_range(23170)) - 11585);
         else if (mode < 8) q[k] = 16'($urandom);
         else q[k] = ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
      end
      // Unit quaternions reach the gimbal-lock neighborhood of pitch.
      if (mode == 5) begin
         q[0] = 16'sd23170; q[2] = 16'sd23170;
         q[1] = 16'($signed($urandom_range(64)) - 32);
         q[3] = 16'($signed($urandom_range(64)) - 32);
      end
      send_quaternion(q[0], q[1], q[2], q[3]);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Identity, extremes, each axis, gimbal lock and zero vectors.
      send_quaternion(16'sh7FFF, 0, 0, 0);
      send_quaternion(0, 0, 0, 0);
      send_quaternion(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_quaternion(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_quaternion(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_quaternion(0, 16'sh7FFF, 0, 0);
      send_quaternion(0, 0, 16'sh7FFF, 0);
      send_quaternion(0, 0, 0, 16'sh7FFF);
      send_quaternion(0, 16'sh8000, 0, 0);
      send_quaternion(0, 0, 0, 16'sh8000);
      send_quaternion(16'sd23170, 0, 16'sd23170, 0);
      send_quaternion(16'sd23170, 0, -16'sd23170, 0);
      send_quaternion(16'sd23170, 16'sd23170, 0, 0);
      send_quaternion(16'sd23170, -16'sd23170, 0, 0);
      send_quaternion(16'sd23170, 0, 0, 16'sd23170);
      send_quaternion(16'sd23170, 0, 0, -16'sd23170);
      send_quaternion(16'sd23170, 16'sd23170, 16'sd23170, 0);
      send_quaternion(0, 16'sd23170, 0, 16'sd23170);
      send_quaternion(16'sd1, -16'sd1, 16'sd1, -16'sd1);
      send_quaternion(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);

      for (int n = 0; n < 1200; n++) begin
         if (n == 300) begin
            // Pause the sender until the pipeline has drained completely.
            req_valid <= 0;
            do @(posedge clock); while (board.pending.size() != 0);
         end
         if (n == 500) begin
            fork
               begin
                  hold_off = 1;
                  repeat (200) @(posedge clock);
                  hold_off = 0;
               end
            join_none
         end
         calm_phase = (n >= 800 && n < 950);
         send_random();
      end
      calm_phase = 0;
      req_valid <= 0;
      do @(posedge clock); while (board.pending.size() != 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d quaternions, checked %0d angle triples incl. extremes,",
               sent, board.matched);
      $display("gimbal lock, zero vectors, drain and back-pressure phases.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
